/* sv/ayp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ayp_pkg
// Shared widths, types and the arctangent table for the aim angle pipeline.
// ----------------------------------------------------------------------------
package ayp_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    // Differences are brought to a fixed 29-bit magnitude before any math.
    localparam int SCALE_EXP = 29 - COORD_WIDTH;
    localparam int SH_L      = (SCALE_EXP > 0) ? SCALE_EXP : 0;
    localparam int SH_R      = (SCALE_EXP < 0) ? -SCALE_EXP : 0;
    localparam int DIFF_W    = COORD_WIDTH + 1;
    localparam int SCALE_W   = 30;

    localparam int CORD_W      = SCALE_W + 4;
    localparam int HSQ_W       = 2 * SCALE_W;
    localparam int ROOT_STAGES = HSQ_W / 2;
    localparam int ROOT_W      = SCALE_W;
    localparam int Z_W         = 26;
    localparam int ANG_W       = 28;
    localparam int YAW_W       = 25;
    localparam int PITCH_W     = 24;

    localparam int IN_BITS  = 6 * COORD_WIDTH;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = YAW_W + PITCH_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam int DEG90_Q16  = 90 * 65536;
    localparam int DEG180_Q16 = 180 * 65536;
    localparam int DEG360_Q16 = 360 * 65536;

    typedef logic signed [CORD_W-1:0] cord_t;
    typedef logic signed [Z_W-1:0]    zang_t;

    typedef struct packed {
        logic same;
        logic c_pos;
        logic c_neg;
        logic theta_zero;
        logic off_pos;
        logic off_neg;
    } side_t;

    // atan(2^-i) in degrees, Q.16, rounded to nearest.
    function automatic zang_t atan_q16(input int unsigned idx);
        zang_t t;
        case (idx)
            0:       t = Z_W'(2949120);
            1:       t = Z_W'(1740967);
            2:       t = Z_W'(919879);
            3:       t = Z_W'(466945);
            4:       t = Z_W'(234379);
            5:       t = Z_W'(117304);
            6:       t = Z_W'(58666);
            7:       t = Z_W'(29335);
            8:       t = Z_W'(14668);
            9:       t = Z_W'(7334);
            10:      t = Z_W'(3667);
            11:      t = Z_W'(1833);
            12:      t = Z_W'(917);
            13:      t = Z_W'(458);
            14:      t = Z_W'(229);
            15:      t = Z_W'(115);
            16:      t = Z_W'(57);
            17:      t = Z_W'(29);
            18:      t = Z_W'(14);
            19:      t = Z_W'(7);
            20:      t = Z_W'(4);
            21:      t = Z_W'(2);
            22:      t = Z_W'(1);
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

/* sv/ayp_cordic_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ayp_cordic_pipe
// Unrolled CORDIC vectoring pipeline, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module ayp_cordic_pipe
    import ayp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  cord_t in_y,
    input  cord_t in_x,
    output logic  out_valid,
    output zang_t out_z
);

    cord_t x_reg [NSTEPS];
    cord_t y_reg [NSTEPS];
    zang_t z_reg [NSTEPS];
    logic  v_reg [NSTEPS];

    cord_t x_next [NSTEPS];
    cord_t y_next [NSTEPS];
    zang_t z_next [NSTEPS];

    always_comb
    begin
        for (int i = 0; i < NSTEPS; i++)
        begin
            cord_t xp;
            cord_t yp;
            zang_t zp;
            if (i == 0)
            begin
                xp = in_x;
                yp = in_y;
                zp = '0;
            end
            else
            begin
                xp = x_reg[i-1];
                yp = y_reg[i-1];
                zp = z_reg[i-1];
            end
            if (yp > 0)
            begin
                x_next[i] = xp + (yp >>> i);
                y_next[i] = yp - (xp >>> i);
                z_next[i] = zp + atan_q16(i);
            end
            else
            begin
                x_next[i] = xp - (yp >>> i);
                y_next[i] = yp + (xp >>> i);
                z_next[i] = zp - atan_q16(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTEPS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < NSTEPS; i++)
            begin
                v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NSTEPS; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    assign out_valid = v_reg[NSTEPS-1];
    assign out_z     = z_reg[NSTEPS-1];

endmodule

/* sv/ayp_isqrt_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ayp_isqrt_pipe
// Pipelined floor integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module ayp_isqrt_pipe
    import ayp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [HSQ_W-1:0]  in_val,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root
);

    localparam int R_W = HSQ_W + 1;

    logic [R_W-1:0] rem_reg [ROOT_STAGES];
    logic [R_W-1:0] res_reg [ROOT_STAGES];
    logic           v_reg   [ROOT_STAGES];

    logic [R_W-1:0] rem_next [ROOT_STAGES];
    logic [R_W-1:0] res_next [ROOT_STAGES];

    always_comb
    begin
        for (int k = 0; k < ROOT_STAGES; k++)
        begin
            logic [R_W-1:0] rp;
            logic [R_W-1:0] sp;
            logic [R_W-1:0] bitv;
            logic [R_W-1:0] trial;
            if (k == 0)
            begin
                rp = R_W'(in_val);
                sp = '0;
            end
            else
            begin
                rp = rem_reg[k-1];
                sp = res_reg[k-1];
            end
            bitv  = R_W'(1) << (2 * (ROOT_STAGES - 1 - k));
            trial = sp + bitv;
            if (rp >= trial)
            begin
                rem_next[k] = rp - trial;
                res_next[k] = (sp >> 1) + bitv;
            end
            else
            begin
                rem_next[k] = rp;
                res_next[k] = sp >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_STAGES; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < ROOT_STAGES; k++)
            begin
                v_reg[k] <= (k == 0) ? in_valid : v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
            end
        end
    end

    assign out_valid = v_reg[ROOT_STAGES-1];
    assign out_root  = res_reg[ROOT_STAGES-1][ROOT_W-1:0];

endmodule

/* sv/aim_yaw_pitch_from_points_top.sv */
`timescale 1ns / 1ps
// Path: difference, square and sum registers, square root, pitch CORDIC, output register.
// One beat per cycle when not stalled; the square root and CORDIC pipelines set the depth.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// aim_yaw_pitch_from_points_top
// Yaw and pitch aim angles from a source point to a destination point.
// ----------------------------------------------------------------------------
module aim_yaw_pitch_from_points_top
    import ayp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // src_x, src_y, src_z, dst_x, dst_y, dst_z
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // yaw_deg, pitch_deg, zero pad
    output logic [OUT_W-1:0] m_tdata,
    // coincident
    output logic             m_tuser
);

    localparam int DS = ROOT_STAGES + NSTEPS + 2;
    localparam int DY = ROOT_STAGES + 2;
    localparam int DH = NSTEPS;

    typedef logic signed [SCALE_W-1:0] scl_t;

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Stage 1: scaled differences.
    scl_t sc_next [3];
    logic same_next;

    always_comb
    begin
        logic signed [DIFF_W-1:0]      d;
        logic signed [DIFF_W+SH_L-1:0] t;
        same_next = 1'b1;
        for (int j = 0; j < 3; j++)
        begin
            d = DIFF_W'($signed(s_tdata[(j+3)*COORD_WIDTH +: COORD_WIDTH]))
              - DIFF_W'($signed(s_tdata[j*COORD_WIDTH +: COORD_WIDTH]));
            if (d != 0)
            begin
                same_next = 1'b0;
            end
            t = ((DIFF_W+SH_L)'(d) <<< SH_L) >>> SH_R;
            sc_next[j] = SCALE_W'(t);
        end
    end

    scl_t a_reg, b_reg, c_reg;
    logic same_reg;
    logic v1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= sc_next[0];
            b_reg    <= sc_next[1];
            c_reg    <= sc_next[2];
            same_reg <= same_next;
        end
    end

    // Yaw vectoring setup: a negative second argument turns the vector by 180 degrees.
    cord_t yaw_y, yaw_x;
    side_t side_in;

    always_comb
    begin
        if (b_reg < 0)
        begin
            yaw_y = -CORD_W'(a_reg);
            yaw_x = -CORD_W'(b_reg);
        end
        else
        begin
            yaw_y = CORD_W'(a_reg);
            yaw_x = CORD_W'(b_reg);
        end
        side_in.same       = same_reg;
        side_in.c_pos      = c_reg > 0;
        side_in.c_neg      = c_reg < 0;
        side_in.theta_zero = (a_reg == 0) && (b_reg == 0);
        side_in.off_pos    = (b_reg < 0) && (a_reg >= 0);
        side_in.off_neg    = (b_reg < 0) && (a_reg < 0);
    end

    // Stages 2 and 3: squares and their sum.
    logic signed [HSQ_W-1:0] sqa_reg, sqb_reg;
    logic [HSQ_W-1:0]        hsq_reg;
    logic                    v2_reg, v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqa_reg <= HSQ_W'(a_reg) * HSQ_W'(a_reg);
            sqb_reg <= HSQ_W'(b_reg) * HSQ_W'(b_reg);
            hsq_reg <= HSQ_W'($unsigned(sqa_reg)) + HSQ_W'($unsigned(sqb_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    logic  yaw_valid;
    zang_t yaw_z;

    ayp_cordic_pipe u_yaw_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .in_y      (yaw_y),
        .in_x      (yaw_x),
        .out_valid (yaw_valid),
        .out_z     (yaw_z)
    );

    logic              h_valid;
    logic [ROOT_W-1:0] h_root;

    ayp_isqrt_pipe u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_val    (hsq_reg),
        .out_valid (h_valid),
        .out_root  (h_root)
    );

    // The pitch CORDIC needs dz aligned with the root; it rides a delay line of its own.
    localparam int DC = 2 + ROOT_STAGES;
    scl_t  c_dly_reg [DC];
    scl_t  c_dly_out;
    side_t side_reg  [DS];
    zang_t yz_reg    [DY];
    logic  hz_reg    [DH];

    assign c_dly_out = c_dly_reg[DC-1];

    logic  p_valid;
    zang_t p_z;

    ayp_cordic_pipe u_pitch_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h_valid),
        .in_y      (CORD_W'(c_dly_out)),
        .in_x      (CORD_W'({1'b0, h_root})),
        .out_valid (p_valid),
        .out_z     (p_z)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DC; i++)
            begin
                c_dly_reg[i] <= (i == 0) ? c_reg : c_dly_reg[i-1];
            end
            for (int i = 0; i < DS; i++)
            begin
                side_reg[i] <= (i == 0) ? side_in : side_reg[i-1];
            end
            for (int i = 0; i < DY; i++)
            begin
                yz_reg[i] <= (i == 0) ? yaw_z : yz_reg[i-1];
            end
            for (int i = 0; i < DH; i++)
            begin
                hz_reg[i] <= (i == 0) ? (h_root == '0) : hz_reg[i-1];
            end
        end
    end

    // Output stage: offsets, wrap and the special cases.
    side_t sd;
    logic signed [ANG_W-1:0] base, yaw_a, yaw_lo, yaw_hi, pz;
    logic [YAW_W-1:0]        yaw_next;
    logic [PITCH_W-1:0]      pitch_next;

    always_comb
    begin
        sd = side_reg[DS-1];
        // 180 minus the half-turn offset is folded into one constant.
        if (sd.off_pos)
        begin
            base = '0;
        end
        else if (sd.off_neg)
        begin
            base = ANG_W'(DEG360_Q16);
        end
        else
        begin
            base = ANG_W'(DEG180_Q16);
        end
        yaw_a = base - ANG_W'(yz_reg[DY-1]);
        if (sd.theta_zero)
        begin
            yaw_a = ANG_W'(DEG180_Q16);
        end
        yaw_lo = yaw_a + ANG_W'(DEG360_Q16);
        yaw_hi = yaw_a - ANG_W'(DEG360_Q16);
        if (yaw_a < 0)
        begin
            yaw_a = yaw_lo;
        end
        else if (yaw_a >= ANG_W'(DEG360_Q16))
        begin
            yaw_a = yaw_hi;
        end
        yaw_next = yaw_a[YAW_W-1:0];

        pz = ANG_W'(p_z);
        if (sd.same)
        begin
            pz = '0;
        end
        else if (hz_reg[DH-1])
        begin
            pz = sd.c_pos ? ANG_W'(DEG90_Q16) : (sd.c_neg ? -ANG_W'(DEG90_Q16) : '0);
        end
        else if (pz > ANG_W'(DEG90_Q16))
        begin
            pz = ANG_W'(DEG90_Q16);
        end
        else if (pz < -ANG_W'(DEG90_Q16))
        begin
            pz = -ANG_W'(DEG90_Q16);
        end
        pitch_next = pz[PITCH_W-1:0];
    end

    logic [YAW_W-1:0]   yaw_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic               same_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= p_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_reg      <= yaw_next;
            pitch_reg    <= pitch_next;
            same_out_reg <= sd.same;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({pitch_reg, yaw_reg});
    assign m_tuser  = same_out_reg;

    // The yaw beat is consumed only through the aligned delay line.
    logic unused_yaw_valid;
    assign unused_yaw_valid = yaw_valid;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the yaw and pitch aim angle pipeline.
// A table of directed point pairs runs first. Random pairs with random stalls on
// both sides follow. Every output beat is compared with a fixed expectation or an
// in-bench model of the CORDIC datapath.
// ----------------------------------------------------------------------------
module tb_top;
    import ayp_pkg::*;

    localparam int N_RANDOM   = 1530;
    localparam int WATCHDOG   = 20000;
    localparam int DRAIN_WAIT = 120;

    typedef struct {
        logic [24:0] yaw;
        logic [23:0] pitch;
        logic        same;
    } aim_t;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] p [6];
        logic                          has_fixed;
        aim_t                          fixed;
    } pair_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;

    aim_t      aim_queue [$];
    pair_row_t rows [$];
    int        n_mismatch;
    int        n_checked;
    int        n_coincident;
    int        n_vertical;
    int        idle_cycles;
    bit        all_sent;
    bit        hold_off;
    bit        calm_in;
    bit        calm_out;

    longint atan_lut [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                              14668, 7334, 3667, 1833, 917, 458, 229, 115,
                              57, 29, 14, 7, 4, 2, 1, 0};

    aim_yaw_pitch_from_points_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint scaled(longint d);
        if (SCALE_EXP >= 0)
            return d <<< SCALE_EXP;
        return d >>> (-SCALE_EXP);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        for (int i = 0; i < NSTEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z += atan_lut[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= atan_lut[i];
            end
        end
        return z;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic aim_t predict_aim(pair_row_t r);
        aim_t   o;
        longint dx;
        longint dy;
        longint dz;
        longint a;
        longint b;
        longint c;
        longint theta;
        longint yaw;
        longint pitch;
        longint h;
        bit     same;
        dx = longint'(r.p[3]) - longint'(r.p[0]);
        dy = longint'(r.p[4]) - longint'(r.p[1]);
        dz = longint'(r.p[5]) - longint'(r.p[2]);
        a = scaled(dx);
        b = scaled(dy);
        c = scaled(dz);
        same = (dx == 0 && dy == 0 && dz == 0);
        if (a == 0 && b == 0)
            theta = 0;
        else if (b < 0)
            theta = (a >= 0 ? DEG180_Q16 : -DEG180_Q16) + vector_angle(-a, -b);
        else
            theta = vector_angle(a, b);
        yaw = DEG180_Q16 - theta;
        if (yaw < 0)
            yaw += DEG360_Q16;
        if (yaw >= DEG360_Q16)
            yaw -= DEG360_Q16;
        h = floor_sqrt(longint'(a * a + b * b));
        if (same)
            pitch = 0;
        else if (h == 0)
            pitch = (c > 0) ? DEG90_Q16 : (c < 0 ? -DEG90_Q16 : 0);
        else
        begin
            pitch = vector_angle(c, h);
            if (pitch > DEG90_Q16)
                pitch = DEG90_Q16;
            if (pitch < -DEG90_Q16)
                pitch = -DEG90_Q16;
        end
        o.yaw   = yaw[24:0];
        o.pitch = pitch[23:0];
        o.same  = same;
        return o;
    endfunction

    function automatic pair_row_t make_pair(int sx, int sy, int sz, int ex, int ey, int ez);
        pair_row_t r;
        r.p[0] = sx[COORD_WIDTH-1:0];
        r.p[1] = sy[COORD_WIDTH-1:0];
        r.p[2] = sz[COORD_WIDTH-1:0];
        r.p[3] = ex[COORD_WIDTH-1:0];
        r.p[4] = ey[COORD_WIDTH-1:0];
        r.p[5] = ez[COORD_WIDTH-1:0];
        r.has_fixed = 1'b0;
        r.fixed = '{default: '0};
        return r;
    endfunction

    function automatic pair_row_t fixed_pair(pair_row_t r, int yaw, int pitch, bit same);
        r.has_fixed   = 1'b1;
        r.fixed.yaw   = yaw[24:0];
        r.fixed.pitch = pitch[23:0];
        r.fixed.same  = same;
        return r;
    endfunction

    function automatic int rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 4000) - 2000;
            2: return ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
            default: return $urandom_range(0, 64) - 32;
        endcase
    endfunction

    function automatic pair_row_t random_pair();
        pair_row_t r;
        int        m;
        int        v;
        m = $urandom_range(0, 3);
        for (int k = 0; k < 6; k++)
        begin
            v = rand_coord(m);
            r.p[k] = v[COORD_WIDTH-1:0];
        end
        // Some pairs share a source and destination on one or more axes.
        case ($urandom_range(0, 9))
            0: for (int k = 0; k < 3; k++) r.p[k+3] = r.p[k];
            1: r.p[5] = r.p[2];
            2:
            begin
                r.p[3] = r.p[0];
                r.p[4] = r.p[1];
            end
            3: r.p[4] = r.p[1];
            default: ;
        endcase
        r.has_fixed = 1'b0;
        return r;
    endfunction

    task automatic send_pair(pair_row_t r);
        logic [IN_W-1:0] w;
        w = '0;
        for (int k = 0; k < 6; k++)
            w[k*COORD_WIDTH +: COORD_WIDTH] = r.p[k];
        while (!calm_in && $urandom_range(0, 99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        aim_queue.push_back(r.has_fixed ? r.fixed : predict_aim(r));
    endtask

    // Stimulus
    initial
    begin
        pair_row_t r;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        all_sent = 1'b0;
        calm_in  = 1'b0;
        rows.push_back(fixed_pair(make_pair(0, 0, 0, 0, 0, 0), DEG180_Q16, 0, 1'b1));
        rows.push_back(fixed_pair(make_pair(5, -7, 9, 5, -7, 9), DEG180_Q16, 0, 1'b1));
        rows.push_back(fixed_pair(make_pair(0, 0, 0, 0, 0, 256), DEG180_Q16, DEG90_Q16, 1'b0));
        rows.push_back(fixed_pair(make_pair(0, 0, 0, 0, 0, -256), DEG180_Q16, -DEG90_Q16,
                                  1'b0));
        rows.push_back(fixed_pair(make_pair(0, 0, -8388608, 0, 0, 8388607), DEG180_Q16,
                                  DEG90_Q16, 1'b0));
        rows.push_back(fixed_pair(make_pair(-8388608, -8388608, -8388608, -8388608, -8388608,
                                            -8388608), DEG180_Q16, 0, 1'b1));
        rows.push_back(make_pair(0, 0, 0, 0, 256, 0));
        rows.push_back(make_pair(0, 0, 0, 0, -256, 0));
        rows.push_back(make_pair(0, 0, 0, 256, 0, 0));
        rows.push_back(make_pair(0, 0, 0, -256, 0, 0));
        rows.push_back(make_pair(0, 0, 0, -1, -256, 0));
        rows.push_back(make_pair(0, 0, 0, 1, -256, 0));
        rows.push_back(make_pair(0, 0, 0, 256, 256, 256));
        rows.push_back(make_pair(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
        rows.push_back(make_pair(8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
        rows.push_back(make_pair(8388607, -8388608, 0, -8388608, 8388607, -1));
        rows.push_back(make_pair(0, 0, 0, 1, 0, 0));
        rows.push_back(make_pair(0, 0, 0, 0, 1, -1));
        rows.push_back(make_pair(0, 0, 0, 1, 1, 8388607));
        rows.push_back(make_pair(0, 0, 8388607, 0, 1, -8388608));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_pair(rows[i]);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm_in = (i >= 600 && i < 800);
            r = random_pair();
            send_pair(r);
        end
        s_tvalid <= 1'b0;
        all_sent = 1'b1;
    end

    // Receiver side: random stalls, one long hold-off while the sender keeps going.
    initial
    begin
        m_tready  = 1'b0;
        hold_off  = 1'b0;
        calm_out  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (n_checked >= 300 && !hold_off)
            begin
                hold_off = 1'b1;
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            calm_out = (n_checked >= 900 && n_checked < 1100);
            m_tready <= calm_out || ($urandom_range(0, 99) >= 34);
        end
    end

    // Output checker
    always @(posedge clk)
    begin
        aim_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (aim_queue.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: output beat with no prediction waiting");
            end
            else
            begin
                want = aim_queue.pop_front();
                n_checked++;
                if (want.same)
                    n_coincident++;
                if (!want.same && (want.pitch == 24'(DEG90_Q16) ||
                                   want.pitch == 24'(-DEG90_Q16)))
                    n_vertical++;
                if (m_tdata[24:0] !== want.yaw || m_tdata[48:25] !== want.pitch ||
                    m_tuser !== want.same)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: beat %0d yaw %h/%h pitch %h/%h same %b/%b (exp/act)",
                                 n_checked, want.yaw, m_tdata[24:0], want.pitch,
                                 m_tdata[48:25], want.same, m_tuser);
                end
            end
        end
    end

    // Watchdog and end of run
    initial
    begin
        n_mismatch   = 0;
        n_checked    = 0;
        n_coincident = 0;
        n_vertical   = 0;
        idle_cycles  = 0;
        @(posedge rst_n);
        while (!(all_sent && aim_queue.size() == 0) && idle_cycles < WATCHDOG)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG)
        begin
            $display("ERROR: no beat moved for %0d cycles", WATCHDOG);
            $display("Simulation FAILED");
        end
        else
        begin
            repeat (DRAIN_WAIT) @(posedge clk);
            $display("Checked %0d aim results: %0d coincident pairs, %0d straight up or down.",
                     n_checked, n_coincident, n_vertical);
            $display("Mismatches: %0d.", n_mismatch);
            if (n_mismatch == 0 && aim_queue.size() == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
sv/ayp_pkg.sv
sv/ayp_cordic_pipe.sv
sv/ayp_isqrt_pipe.sv
sv/aim_yaw_pitch_from_points_top.sv
dv/tb_top.sv
